// File: hdl/bdsl_pkg.sv
// Shared types, constants and codes for the button debounce and press detection block.
package bdsl_pkg;

    // Number of debounced buttons, one lane each.
    localparam int NUM_BUTTONS = 5;
    // Buttons carried in the level field and shown in the held mask.
    localparam int LEVEL_BITS  = 5;

    localparam int TIME_W   = 32;
    localparam int POLL_W   = 8;
    localparam int DEB_W    = 16;
    localparam int LONG_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int INDEX_W  = 3;
    localparam int KIND_W   = 2;
    localparam int PRESS_W  = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Item kinds carried in the slave tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_POLL        = 2'd0,
        KIND_TAKE_BUTTON = 2'd1,
        KIND_TAKE_FOOT   = 2'd2
    } t_kind;

    // Latched press events.
    typedef enum logic [PRESS_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_press;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd2;

    // Register reset values.
    localparam logic [POLL_W-1:0] POLL_RESET = 8'd5;
    localparam logic [DEB_W-1:0]  DEB_RESET  = 16'd30;
    localparam logic [LONG_W-1:0] LONG_RESET = 16'd800;

    // Controls from the top level to one lane.
    typedef struct packed {
        logic sample;
        logic take;
    } t_lane_ctl;

    // Status from one lane to the merging stage.
    typedef struct packed {
        logic   held_next;
        t_press pending;
    } t_lane_sts;

endpackage

// File: hdl/bdsl_lane.sv
// One button lane: debounce, press timing and the latched event of a single button.
module bdsl_lane
    import bdsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic [TIME_W-1:0] i_now_ms,
    input  logic              i_level,
    input  logic [DEB_W-1:0]  i_debounce_ms,
    input  logic [LONG_W-1:0] i_long_press_ms,
    output t_lane_sts         o_sts
);

    logic              r_raw;
    logic [TIME_W-1:0] r_change_time;
    logic              r_stable;
    logic [TIME_W-1:0] r_press_start;
    logic              r_long_done;
    t_press            r_pending;

    logic              n_raw;
    logic [TIME_W-1:0] n_change_time;
    logic              n_stable;
    logic [TIME_W-1:0] n_press_start;
    logic              n_long_done;
    t_press            n_pending;

    logic              raw_chg;
    logic [TIME_W-1:0] deb_diff;
    logic [TIME_W-1:0] long_diff;
    logic              becomes;
    logic              press_edge;
    logic              long_done_mid;
    logic              long_fire;

    // Both elapsed times are formed in parallel from the old timestamps; a
    // timestamp replaced in this sample counts as zero elapsed.
    always_comb begin
        n_raw         = ~i_level;
        raw_chg       = n_raw != r_raw;
        n_change_time = raw_chg ? i_now_ms : r_change_time;
        deb_diff      = raw_chg ? '0 : (i_now_ms - r_change_time);
        becomes       = (deb_diff >= {{(TIME_W-DEB_W){1'b0}}, i_debounce_ms})
                        && (r_stable != n_raw);
        n_stable      = becomes ? n_raw : r_stable;
        press_edge    = becomes && n_raw;
        n_press_start = press_edge ? i_now_ms : r_press_start;
        long_diff     = press_edge ? '0 : (i_now_ms - r_press_start);
        long_done_mid = press_edge ? 1'b0 : r_long_done;
        n_pending     = r_pending;
        if (becomes && !n_raw && !r_long_done) begin
            n_pending = EV_SHORT;
        end
        long_fire     = n_stable && !long_done_mid
                        && (long_diff >= {{(TIME_W-LONG_W){1'b0}}, i_long_press_ms});
        n_long_done   = long_fire ? 1'b1 : long_done_mid;
        if (long_fire) begin
            n_pending = EV_LONG;
        end
    end

    // Lane state: updated by an accepted poll, event cleared by a take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw         <= 1'b0;
            r_change_time <= '0;
            r_stable      <= 1'b0;
            r_press_start <= '0;
            r_long_done   <= 1'b0;
            r_pending     <= EV_NONE;
        end else if (i_ctl.sample) begin
            r_raw         <= n_raw;
            r_change_time <= n_change_time;
            r_stable      <= n_stable;
            r_press_start <= n_press_start;
            r_long_done   <= n_long_done;
            r_pending     <= n_pending;
        end else if (i_ctl.take) begin
            r_pending     <= EV_NONE;
        end
    end

    // The held level after this item and the event as it stands before it.
    assign o_sts.held_next = i_ctl.sample ? n_stable : r_stable;
    assign o_sts.pending   = r_pending;

endmodule

// File: hdl/bdsl_merge.sv
// Merging stage: gathers the lane held bits and selects the event of the addressed button.
module bdsl_merge
    import bdsl_pkg::*;
(
    input  t_lane_sts            i_sts [NUM_BUTTONS],
    input  logic                 i_take,
    input  logic [INDEX_W-1:0]   i_index,
    output t_press               o_press,
    output logic [LEVEL_BITS-1:0] o_held_mask
);

    // Held mask: only the buttons that fit the level field are shown.
    for (genvar j = 0; j < LEVEL_BITS; j++) begin : g_held
        if (j < NUM_BUTTONS) begin : g_on
            assign o_held_mask[j] = i_sts[j].held_next;
        end else begin : g_off
            assign o_held_mask[j] = 1'b0;
        end
    end

    // Event of the addressed button; an index past the last button reads none.
    always_comb begin
        o_press = EV_NONE;
        if (i_take) begin
            for (int k = 0; k < NUM_BUTTONS; k++) begin
                if (int'(i_index) == k) begin
                    o_press = i_sts[k].pending;
                end
            end
        end
    end

endmodule

// File: hdl/button_debounce_short_long_press_unit.sv
// Top level of the button debounce unit with short and long press detection.
//
//  Channel  | Direction | tdata (low bit up)                                  | tuser
//  s_axis   | in        | now_ms 32, button_levels 5, rough_level 1,          | kind 2
//           |           | foot_level 1, button_index 3, zero fill to 48       |
//  m_axis   | out       | press 2, foot_released 1, held_mask 5, rough_mode 1,| none
//           |           | zero fill to 16                                     |
//  cfg      | in        | i_cfg_we, i_cfg_index 2, i_cfg_data 16               | none
//
// All button lanes update in the cycle a poll word past the poll interval is
// accepted, and each word's result is in the output register on the next cycle.
// Throughput is one word per cycle while the master side keeps accepting results.
// Synchronous active-low reset clears all state and loads the register defaults.
// The input is stalled only while a result is held and the master side is not ready.
module button_debounce_short_long_press_unit
    import bdsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // now_ms, button_levels, rough_level, foot_level, button_index, fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // press, foot_released, held_mask, rough_mode, fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [TIME_W-1:0]     now_ms;
    logic [LEVEL_BITS-1:0] button_levels;
    logic                  rough_level;
    logic                  foot_level;
    logic [INDEX_W-1:0]    button_index;
    logic [KIND_W-1:0]     kind;

    logic [POLL_W-1:0] r_poll_interval;
    logic [DEB_W-1:0]  r_debounce;
    logic [LONG_W-1:0] r_long_press;
    logic [TIME_W-1:0] r_last_poll;
    logic              r_foot_pressed;
    logic              r_foot_flag;
    logic              r_rough;
    logic              r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic                  accept;
    logic                  poll_ok;
    logic                  do_sample;
    logic                  do_take;
    logic                  do_foot;
    logic                  n_rough;
    logic                  n_foot_pressed;
    logic                  n_foot_flag;
    logic [NUM_BUTTONS-1:0] lane_level;
    t_lane_ctl             lane_ctl [NUM_BUTTONS];
    t_lane_sts             lane_sts [NUM_BUTTONS];
    t_press                press;
    logic [LEVEL_BITS-1:0] held_mask;

    // Input word unpacking.
    assign now_ms        = s_axis_tdata[31:0];
    assign button_levels = s_axis_tdata[36:32];
    assign rough_level   = s_axis_tdata[37];
    assign foot_level    = s_axis_tdata[38];
    assign button_index  = s_axis_tdata[41:39];
    assign kind          = s_axis_tuser;

    // Handshake: a new word enters whenever the output register frees up.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Decode of the accepted word.
    assign poll_ok   = (now_ms - r_last_poll) >= {{(TIME_W-POLL_W){1'b0}}, r_poll_interval};
    assign do_sample = accept && (kind == KIND_POLL) && poll_ok;
    assign do_take   = accept && (kind == KIND_TAKE_BUTTON);
    assign do_foot   = accept && (kind == KIND_TAKE_FOOT);

    // Lane levels: buttons beyond the level field read as released.
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        if (i < LEVEL_BITS) begin : g_pin
            assign lane_level[i] = button_levels[i];
        end else begin : g_nopin
            assign lane_level[i] = 1'b1;
        end

        assign lane_ctl[i].sample = do_sample;
        assign lane_ctl[i].take   = do_take && (int'(button_index) == i);

        bdsl_lane u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (lane_ctl[i]),
            .i_now_ms        (now_ms),
            .i_level         (lane_level[i]),
            .i_debounce_ms   (r_debounce),
            .i_long_press_ms (r_long_press),
            .o_sts           (lane_sts[i])
        );
    end

    bdsl_merge u_merge (
        .i_sts       (lane_sts),
        .i_take      (do_take),
        .i_index     (button_index),
        .o_press     (press),
        .o_held_mask (held_mask)
    );

    // Shared switch state after this word.
    always_comb begin
        n_rough        = r_rough;
        n_foot_pressed = r_foot_pressed;
        n_foot_flag    = r_foot_flag;
        if (do_sample) begin
            n_rough        = ~rough_level;
            n_foot_pressed = ~foot_level;
            if (r_foot_pressed && foot_level) begin
                n_foot_flag = 1'b1;
            end
        end else if (do_foot) begin
            n_foot_flag = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_interval <= POLL_RESET;
            r_debounce      <= DEB_RESET;
            r_long_press    <= LONG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POLL_INTERVAL: r_poll_interval <= i_cfg_data[POLL_W-1:0];
                CFG_DEBOUNCE:      r_debounce      <= i_cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS:    r_long_press    <= i_cfg_data[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_poll    <= '0;
            r_foot_pressed <= 1'b0;
            r_foot_flag    <= 1'b0;
            r_rough        <= 1'b0;
            r_m_valid      <= 1'b0;
            r_m_data       <= '0;
        end else begin
            if (do_sample) begin
                r_last_poll <= now_ms;
            end
            r_foot_pressed <= n_foot_pressed;
            r_foot_flag    <= n_foot_flag;
            r_rough        <= n_rough;
            if (accept) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {{(M_TDATA_W-PRESS_W-2-LEVEL_BITS){1'b0}}, n_rough, held_mask,
                              do_foot & r_foot_flag, press};
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef ASSERT_OFF
    // A taken foot release flag is cleared.
    a_foot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_foot |=> !r_foot_flag)
        else $error("foot release flag not cleared after take");

    // A poll that comes too early leaves the poll timestamp alone.
    a_early_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (kind == KIND_POLL) && !poll_ok) |=> $stable(r_last_poll))
        else $error("early poll moved the poll timestamp");

    // The press code of a result is always one of the defined events.
    a_press_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[1:0] == EV_NONE) ||
                           (m_axis_tdata[1:0] == EV_SHORT) ||
                           (m_axis_tdata[1:0] == EV_LONG)))
        else $error("invalid press code on result");

    // A result never carries both a press event and a foot release.
    a_one_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !((m_axis_tdata[1:0] != EV_NONE) && m_axis_tdata[2]))
        else $error("press and foot release in one result");
`endif

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the button debounce unit with short and long press detection.
`timescale 1ns / 100ps

module testbench;
    import bdsl_pkg::*;

    // The unused kind code is not part of the package enum.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    // One input word, and one status word as the block reports it.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  now;
        logic [4:0]         levels;
        logic               rough;
        logic               foot;
        logic [INDEX_W-1:0] idx;
    } t_pin_word;

    typedef struct packed {
        t_press     press;
        logic       foot_rel;
        logic [4:0] held;
        logic       rough;
    } t_status_word;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Predicted state of the button lanes, foot switch and rough/fine level.
    logic              lane_raw        [NUM_BUTTONS];
    logic [TIME_W-1:0] lane_change_ms  [NUM_BUTTONS];
    logic              lane_stable     [NUM_BUTTONS];
    logic [TIME_W-1:0] lane_press_ms   [NUM_BUTTONS];
    logic              lane_long_fired [NUM_BUTTONS];
    t_press            lane_event      [NUM_BUTTONS];
    logic [TIME_W-1:0] last_poll_ms;
    logic              foot_down;
    logic              foot_release_seen;
    logic              rough_on;
    logic [POLL_W-1:0] cfg_poll_ms;
    logic [DEB_W-1:0]  cfg_debounce_ms;
    logic [LONG_W-1:0] cfg_long_ms;

    t_status_word expected_status_q[$];
    int           mismatch_count;
    int           cycle_count;
    int           rx_hold_cycles;
    bit           no_idle;

    button_debounce_short_long_press_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Predicted state after reset.
    task automatic clear_press_state();
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            lane_raw[i]        = 1'b0;
            lane_change_ms[i]  = '0;
            lane_stable[i]     = 1'b0;
            lane_press_ms[i]   = '0;
            lane_long_fired[i] = 1'b0;
            lane_event[i]      = EV_NONE;
        end
        last_poll_ms      = '0;
        foot_down         = 1'b0;
        foot_release_seen = 1'b0;
        rough_on          = 1'b0;
        cfg_poll_ms       = POLL_RESET;
        cfg_debounce_ms   = DEB_RESET;
        cfg_long_ms       = LONG_RESET;
    endtask

    // Applies one accepted word to the predicted state and returns the status it causes.
    function automatic t_status_word predict_status(t_pin_word w);
        t_status_word      s;
        logic [TIME_W-1:0] elapsed;
        logic              down;
        s = '0;
        s.press = EV_NONE;
        case (w.kind)
            KIND_POLL: begin
                elapsed = w.now - last_poll_ms;
                if (elapsed >= {24'd0, cfg_poll_ms}) begin
                    last_poll_ms = w.now;
                    for (int i = 0; i < NUM_BUTTONS; i++) begin
                        down = ~w.levels[i];
                        if (down != lane_raw[i]) begin
                            lane_raw[i]       = down;
                            lane_change_ms[i] = w.now;
                        end
                        elapsed = w.now - lane_change_ms[i];
                        if (elapsed >= {16'd0, cfg_debounce_ms} &&
                            lane_stable[i] != lane_raw[i]) begin
                            lane_stable[i] = lane_raw[i];
                            if (lane_stable[i]) begin
                                lane_press_ms[i]   = w.now;
                                lane_long_fired[i] = 1'b0;
                            end else if (!lane_long_fired[i]) begin
                                lane_event[i] = EV_SHORT;
                            end
                        end
                        elapsed = w.now - lane_press_ms[i];
                        if (lane_stable[i] && !lane_long_fired[i] &&
                            elapsed >= {16'd0, cfg_long_ms}) begin
                            lane_long_fired[i] = 1'b1;
                            lane_event[i]      = EV_LONG;
                        end
                    end
                    rough_on = ~w.rough;
                    if (foot_down && w.foot)
                        foot_release_seen = 1'b1;
                    foot_down = ~w.foot;
                end
            end
            KIND_TAKE_BUTTON: begin
                if (w.idx < NUM_BUTTONS) begin
                    s.press           = lane_event[w.idx];
                    lane_event[w.idx] = EV_NONE;
                end
            end
            KIND_TAKE_FOOT: begin
                s.foot_rel        = foot_release_seen;
                foot_release_seen = 1'b0;
            end
            default: ;
        endcase
        for (int i = 0; i < LEVEL_BITS; i++)
            s.held[i] = lane_stable[i];
        s.rough = rough_on;
        return s;
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Offers one word after a random gap and predicts its status once it is accepted.
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                             input logic [4:0] levels, input logic rough, input logic foot,
                             input logic [INDEX_W-1:0] idx);
        t_pin_word w;
        int        gap;
        w.kind   = kind;
        w.now    = now;
        w.levels = levels;
        w.rough  = rough;
        w.foot   = foot;
        w.idx    = idx;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {6'd0, idx, foot, rough, levels, now};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_status_q.push_back(predict_status(w));
    endtask

    task automatic poll_at(input logic [TIME_W-1:0] now, input logic [4:0] levels,
                           input logic rough, input logic foot);
        send_word(KIND_POLL, now, levels, rough, foot, INDEX_W'($urandom));
    endtask

    // Take words carry random filler in the fields they do not use.
    task automatic take_button(input logic [INDEX_W-1:0] idx);
        send_word(KIND_TAKE_BUTTON, $urandom, 5'($urandom), 1'($urandom), 1'($urandom), idx);
    endtask

    task automatic take_foot();
        send_word(KIND_TAKE_FOOT, $urandom, 5'($urandom), 1'($urandom), 1'($urandom),
                  INDEX_W'($urandom));
    endtask

    task automatic send_unused_kind();
        send_word(KIND_UNUSED, $urandom, 5'($urandom), 1'($urandom), 1'($urandom),
                  INDEX_W'($urandom));
    endtask

    // Stops offering and waits until every predicted status has come back.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            CFG_POLL_INTERVAL: cfg_poll_ms     = value[POLL_W-1:0];
            CFG_DEBOUNCE:      cfg_debounce_ms = value[DEB_W-1:0];
            CFG_LONG_PRESS:    cfg_long_ms     = value[LONG_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Default registers: early polls after reset, a short and a long press, the foot
    // release latch, out-of-range take indexes and the unused kind.
    task automatic test_after_reset();
        poll_at(32'd0, 5'b11111, 1'b1, 1'b1);
        poll_at(32'd4, 5'b00000, 1'b0, 1'b0);
        poll_at(32'd5, 5'b11100, 1'b0, 1'b0);
        poll_at(32'd35, 5'b11100, 1'b1, 1'b0);
        poll_at(32'd100, 5'b11110, 1'b1, 1'b1);
        take_foot();
        take_foot();
        poll_at(32'd130, 5'b11110, 1'b1, 1'b1);
        take_button(3'd1);
        take_button(3'd1);
        poll_at(32'd835, 5'b11110, 1'b1, 1'b1);
        take_button(3'd0);
        take_button(3'd5);
        take_button(3'd7);
        send_unused_kind();
        drain();
    endtask

    // Registers at zero and at their maximum, with timestamps across the wrap.
    task automatic test_register_extremes();
        write_reg(CFG_POLL_INTERVAL, 16'd0);
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'd0);
        poll_at(32'hFFFF_FFFF, 5'b01010, 1'b0, 1'b0);
        poll_at(32'hFFFF_FFFF, 5'b11111, 1'b1, 1'b1);
        take_button(3'd0);
        take_button(3'd4);
        take_foot();
        drain();
        write_reg(CFG_POLL_INTERVAL, 16'd255);
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        poll_at(32'h0000_00FE, 5'b00000, 1'b0, 1'b1);
        poll_at(32'h0000_01FC, 5'b11111, 1'b1, 1'b0);
        poll_at(32'h0001_00FD, 5'b00000, 1'b0, 1'b1);
        poll_at(32'h0002_00FC, 5'b00000, 1'b0, 1'b1);
        take_button(3'd3);
        drain();
    endtask

    // One setting of the registers, then button sessions with random timing, contact
    // bounce and take words mixed in, starting from a random timestamp.
    task automatic run_press_phase(input int count, input int poll, input int deb,
                                   input int lng, input bit quiet, input int hold);
        logic [TIME_W-1:0] now;
        logic [4:0]        levels;
        logic              rough;
        logic              foot;
        int                step_max;
        int                r;
        int                k;
        write_reg(CFG_POLL_INTERVAL, CFG_W'(poll));
        write_reg(CFG_DEBOUNCE, CFG_W'(deb));
        write_reg(CFG_LONG_PRESS, CFG_W'(lng));
        no_idle        = quiet;
        rx_hold_cycles = hold;
        now      = $urandom;
        levels   = 5'h1F;
        rough    = 1'($urandom);
        foot     = 1'($urandom);
        step_max = poll + deb / 4 + lng / 16 + 2;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 62) begin
                now = now + $urandom_range(0, step_max);
                if ($urandom_range(0, 7) == 0) begin
                    k = $urandom_range(0, 4);
                    levels[k] = ~levels[k];
                end
                if ($urandom_range(0, 19) == 0)
                    rough = ~rough;
                if ($urandom_range(0, 15) == 0)
                    foot = ~foot;
                // Contact bounce: one sample with some pins flipped.
                if ($urandom_range(0, 19) == 0)
                    poll_at(now, levels ^ 5'($urandom_range(1, 31)), rough, foot);
                else
                    poll_at(now, levels, rough, foot);
            end else if (r < 88) begin
                take_button(INDEX_W'($urandom_range(0, 7)));
            end else if (r < 96) begin
                take_foot();
            end else begin
                send_unused_kind();
            end
        end
        drain();
        no_idle = 1'b0;
    endtask

    task automatic test_random_presses();
        run_press_phase(120, 1, 4, 20, 1'b0, 0);
        run_press_phase(100, 0, 0, 8, 1'b1, 0);
        run_press_phase(120, 3, 10, 60, 1'b0, 0);
        run_press_phase(100, 5, 30, 800, 1'b0, 0);
        run_press_phase(80, 255, 65535, 65535, 1'b0, 0);
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_stall();
        run_press_phase(60, 2, 5, 30, 1'b1, 300);
    endtask

    // Receiver: random stalls, plus the long hold-off when one is requested.
    initial begin
        int stall_left;
        int gap;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    stall_left = gap - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input t_status_word want,
                                   input t_status_word got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%0t %s: expected press %0d foot %0d held %b rough %0d, ",
                   $realtime, what, want.press, want.foot_rel, want.held, want.rough);
            $display("got press %0d foot %0d held %b rough %0d",
                     got.press, got.foot_rel, got.held, got.rough);
        end
    endtask

    // Each status word is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_status_word got;
        t_status_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.press    = t_press'(m_axis_tdata[1:0]);
            got.foot_rel = m_axis_tdata[2];
            got.held     = m_axis_tdata[7:3];
            got.rough    = m_axis_tdata[8];
            if (expected_status_q.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
            end else begin
                want = expected_status_q.pop_front();
                if (got.press !== want.press || got.foot_rel !== want.foot_rel ||
                    got.held !== want.held || got.rough !== want.rough)
                    report_mismatch("status mismatch", want, got);
            end
        end
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** button_debounce_short_long_press_unit: FAILED **");
        $finish;
    end

    initial begin
        clear_press_state();
        mismatch_count = 0;
        rx_hold_cycles = 0;
        no_idle        = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_register_extremes();
        test_random_presses();
        test_output_stall();
        drain();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && expected_status_q.size() == 0)
            $display("** button_debounce_short_long_press_unit: PASSED **");
        else
            $display("** button_debounce_short_long_press_unit: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hdl/bdsl_pkg.sv
hdl/bdsl_lane.sv
hdl/bdsl_merge.sv
hdl/button_debounce_short_long_press_unit.sv
sim/testbench.sv
